// ===== src/timed_actuator_sequencer_top_defines.svh =====
// Assertion macros for the timed actuator sequencer checker.
`ifndef TIMED_ACTUATOR_SEQUENCER_TOP_DEFINES_SVH
`define TIMED_ACTUATOR_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TAS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tas_pkg.sv =====
package tas_pkg;

   localparam int TICK_WIDTH  = 31;
   localparam int SINCE_WIDTH = 32;

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_COUNTDOWN = 2'd1,
      PH_EXTEND    = 2'd2,
      PH_RETRACT   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      MOTOR_STOP    = 2'd0,
      MOTOR_EXTEND  = 2'd1,
      MOTOR_RETRACT = 2'd2
   } motor_type;

   typedef enum logic [1:0] {
      CSR_IDLE_TICKS      = 2'd0,
      CSR_COUNTDOWN_TICKS = 2'd1,
      CSR_MOVE_TICKS      = 2'd2,
      CSR_LOCKOUT_TICKS   = 2'd3
   } csr_index_type;

   localparam logic [TICK_WIDTH-1:0] IDLE_TICKS_RESET      = 31'd1;
   localparam logic [TICK_WIDTH-1:0] COUNTDOWN_TICKS_RESET = 31'd1200000;
   localparam logic [TICK_WIDTH-1:0] MOVE_TICKS_RESET      = 31'd12500;
   localparam logic [TICK_WIDTH-1:0] LOCKOUT_TICKS_RESET   = 31'd500;

   typedef struct packed {
      logic green_button;
      logic red_button;
   } req_payload_type;

   typedef struct packed {
      phase_type phase;
      motor_type motor_drive;
      logic      green_light;
      logic      red_light;
      logic      extended_flag;
   } rsp_payload_type;

   // Broadcast to every queue cell once per tick.
   typedef struct packed {
      logic      step;        // tick accepted: cells update
      logic      shift;       // head expired: take neighbor's entry
      logic      set1;        // overwrite entry 1
      phase_type set1_phase;
      logic      fill;        // entries 2..4 get retract, countdown, extend
      logic      clr1;        // idle from entry 1 on
      logic      clr2;        // idle from entry 2 on
      logic      clr5;        // idle from entry 5 on
   } queue_cmd_type;

   // Post-tick state handed to the light stage.
   typedef struct packed {
      phase_type               phase;
      logic [TICK_WIDTH-1:0]   time_left;
      logic                    extended;
   } blink_item_type;

endpackage

// ===== src/tas_cell.sv =====
module tas_cell #(
   parameter int INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tas_pkg::queue_cmd_type  cmd,
   input  tas_pkg::phase_type      right_in,
   output tas_pkg::phase_type      phase_out
);
   import tas_pkg::*;

   phase_type entry_ff;
   phase_type entry_in;
   phase_type base;

   always_comb begin
      base = cmd.shift ? right_in : entry_ff;
      entry_in = entry_ff;
      if (cmd.step) begin
         if (INDEX == 1 && cmd.set1) begin
            entry_in = cmd.set1_phase;
         end else if (cmd.fill && INDEX == 2) begin
            entry_in = PH_RETRACT;
         end else if (cmd.fill && INDEX == 3) begin
            entry_in = PH_COUNTDOWN;
         end else if (cmd.fill && INDEX == 4) begin
            entry_in = PH_EXTEND;
         end else if ((cmd.clr1 && INDEX >= 1) || (cmd.clr2 && INDEX >= 2) ||
                      (cmd.clr5 && INDEX >= 5)) begin
            entry_in = PH_IDLE;
         end else begin
            entry_in = base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= PH_IDLE;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign phase_out = entry_ff;

endmodule

// ===== src/tas_blink.sv =====
module tas_blink #(
   parameter int TICKS_PER_SECOND = 1000
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  tas_pkg::blink_item_type  in_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tas_pkg::rsp_payload_type rsp_payload
);
   import tas_pkg::*;

   // floor(x / TPS) == (x * RECIP) >> SHIFT for every x below 2**TICK_WIDTH
   localparam int          SHIFT      = TICK_WIDTH + $clog2(TICKS_PER_SECOND);
   localparam int          PROD_WIDTH = 2 * TICK_WIDTH + 1;
   localparam logic [63:0] RECIP_WIDE = ((64'd1 << SHIFT) + 64'(TICKS_PER_SECOND) - 64'd1)
                                        / 64'(TICKS_PER_SECOND);
   localparam logic [TICK_WIDTH:0] RECIP = RECIP_WIDE[TICK_WIDTH:0];

   logic            s1_valid_ff, s1_valid_in;
   blink_item_type  s1_item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            out_move;
   logic [PROD_WIDTH-1:0] product;
   logic            sec_parity;

   assign out_move = !rsp_valid_ff || rsp_ready;
   assign in_ready = !s1_valid_ff || out_move;
   assign s1_valid_in  = in_ready ? in_valid : s1_valid_ff;
   assign rsp_valid_in = out_move ? s1_valid_ff : rsp_valid_ff;

   assign product    = PROD_WIDTH'(s1_item_ff.time_left) * PROD_WIDTH'(RECIP);
   assign sec_parity = product[SHIFT];

   always_comb begin
      rsp_payload_in               = '0;
      rsp_payload_in.phase         = s1_item_ff.phase;
      rsp_payload_in.extended_flag = s1_item_ff.extended;
      rsp_payload_in.motor_drive   = MOTOR_STOP;
      case (s1_item_ff.phase)
         PH_COUNTDOWN: begin
            rsp_payload_in.green_light = sec_parity;
            rsp_payload_in.red_light   = !sec_parity;
         end
         PH_EXTEND: begin
            rsp_payload_in.green_light = sec_parity;
            rsp_payload_in.motor_drive = MOTOR_EXTEND;
         end
         PH_RETRACT: begin
            rsp_payload_in.red_light   = sec_parity;
            rsp_payload_in.motor_drive = MOTOR_RETRACT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_item_ff <= in_item;
      end
      if (s1_valid_ff && out_move) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== src/timed_actuator_sequencer_top.sv =====
// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_ready  req_payload (green_button, red_button)
// rsp      out  rsp_valid/rsp_ready  rsp_payload (phase, motor, lights, flag)
// csr      in   csr_we               csr_index, csr_wdata
//
// One beat per cycle while rsp_ready is high; each req beat gives one rsp beat through
// the item and rsp registers of the light stage, with the seconds-parity reciprocal
// multiply between them. Queue, counters and flag update in the cycle a beat is taken.
// Synchronous reset clears queue, counters and flag and reloads default durations.
// A stalled rsp holds its beat; req_ready drops only when both light stages
// are full and rsp_ready is low.
module timed_actuator_sequencer_top #(
   parameter int QUEUE_DEPTH      = 6,
   parameter int TICKS_PER_SECOND = 1000
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tas_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tas_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_we,
   input  tas_pkg::csr_index_type    csr_index,
   input  logic [tas_pkg::TICK_WIDTH-1:0] csr_wdata
);
   import tas_pkg::*;

   logic [TICK_WIDTH-1:0]  idle_ticks_ff, countdown_ticks_ff, move_ticks_ff, lockout_ticks_ff;
   logic [TICK_WIDTH-1:0]  time_left_ff, time_left_in;
   logic [SINCE_WIDTH-1:0] since_ff, since_in;
   logic                   is_out_ff, is_out_in;

   phase_type              queue_q [QUEUE_DEPTH];
   queue_cmd_type          queue_cmd;
   blink_item_type         item;

   logic                   accept;
   logic                   expire;
   phase_type              head;
   logic [TICK_WIDTH-1:0]  time_after;
   logic                   unlocked;
   logic                   green, red;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ticks_ff      <= IDLE_TICKS_RESET;
         countdown_ticks_ff <= COUNTDOWN_TICKS_RESET;
         move_ticks_ff      <= MOVE_TICKS_RESET;
         lockout_ticks_ff   <= LOCKOUT_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IDLE_TICKS:      idle_ticks_ff      <= csr_wdata;
            CSR_COUNTDOWN_TICKS: countdown_ticks_ff <= csr_wdata;
            CSR_MOVE_TICKS:      move_ticks_ff      <= csr_wdata;
            CSR_LOCKOUT_TICKS:   lockout_ticks_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         if (gi == QUEUE_DEPTH - 1) begin : g_tail
            tas_cell #(.INDEX(gi)) u_cell (
               .clock     (clock),
               .reset     (reset),
               .cmd       (queue_cmd),
               .right_in  (PH_IDLE),
               .phase_out (queue_q[gi])
            );
         end else begin : g_body
            tas_cell #(.INDEX(gi)) u_cell (
               .clock     (clock),
               .reset     (reset),
               .cmd       (queue_cmd),
               .right_in  (queue_q[gi+1]),
               .phase_out (queue_q[gi])
            );
         end
      end
   endgenerate

   assign accept = req_valid && req_ready;
   assign green  = req_payload.green_button;
   assign red    = req_payload.red_button;
   assign expire = (time_left_ff == '0);
   assign head   = expire ? queue_q[1] : queue_q[0];

   always_comb begin
      is_out_in    = is_out_ff;
      time_after   = time_left_ff - TICK_WIDTH'(1);
      since_in     = (since_ff == '1) ? since_ff : since_ff + SINCE_WIDTH'(1);
      if (expire) begin
         if (queue_q[0] == PH_EXTEND) begin
            is_out_in = 1'b1;
         end else if (queue_q[0] == PH_RETRACT) begin
            is_out_in = 1'b0;
         end
         since_in = '0;
         case (queue_q[1])
            PH_COUNTDOWN:          time_after = countdown_ticks_ff;
            PH_EXTEND, PH_RETRACT: time_after = move_ticks_ff;
            default:               time_after = idle_ticks_ff;
         endcase
      end
   end

   assign unlocked = (since_in >= SINCE_WIDTH'(lockout_ticks_ff));

   // Button handling acts on the queue after this tick's shift.
   always_comb begin
      queue_cmd       = '0;
      queue_cmd.step  = accept;
      queue_cmd.shift = expire;
      queue_cmd.set1_phase = PH_IDLE;
      time_left_in    = time_after;
      if (head == PH_IDLE) begin
         if (red) begin
            queue_cmd.set1       = 1'b1;
            queue_cmd.set1_phase = is_out_in ? PH_RETRACT : PH_EXTEND;
            queue_cmd.clr2       = 1'b1;
         end else if (green) begin
            queue_cmd.set1       = 1'b1;
            queue_cmd.set1_phase = is_out_in ? PH_IDLE : PH_EXTEND;
            queue_cmd.fill       = 1'b1;
            queue_cmd.clr5       = 1'b1;
         end
      end else if (unlocked) begin
         case (head)
            PH_COUNTDOWN: begin
               if (green && red) begin
                  time_left_in = idle_ticks_ff;
               end
            end
            PH_EXTEND: begin
               if (green) begin
                  time_left_in   = idle_ticks_ff;
                  queue_cmd.clr1 = 1'b1;
               end else if (red) begin
                  time_left_in         = idle_ticks_ff;
                  queue_cmd.set1       = 1'b1;
                  queue_cmd.set1_phase = PH_RETRACT;
                  queue_cmd.clr2       = 1'b1;
               end
            end
            default: begin
               if (red) begin
                  time_left_in   = idle_ticks_ff;
                  queue_cmd.clr1 = 1'b1;
               end else if (green) begin
                  time_left_in         = idle_ticks_ff;
                  queue_cmd.set1       = 1'b1;
                  queue_cmd.set1_phase = PH_EXTEND;
                  queue_cmd.clr2       = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_left_ff <= '0;
         since_ff     <= '0;
         is_out_ff    <= 1'b0;
      end else if (accept) begin
         time_left_ff <= time_left_in;
         since_ff     <= since_in;
         is_out_ff    <= is_out_in;
      end
   end

   // Lights follow the time left before any button cut-short.
   assign item.phase     = head;
   assign item.time_left = time_after;
   assign item.extended  = is_out_in;

   tas_blink #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_blink (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_item     (item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== src/tas_checker.sv =====
`include "timed_actuator_sequencer_top_defines.svh"

module tas_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input tas_pkg::rsp_payload_type  rsp_payload
);
   import tas_pkg::*;

   `TAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload), "rsp beat changed while stalled")

   `TAS_ASSERT_NOW(a_idle_dark, clock, reset, rsp_valid && rsp_payload.phase == PH_IDLE,
      rsp_payload.motor_drive == MOTOR_STOP && !rsp_payload.green_light &&
      !rsp_payload.red_light, "idle beat with motor or light on")

   `TAS_ASSERT_NOW(a_countdown_one_light, clock, reset,
      rsp_valid && rsp_payload.phase == PH_COUNTDOWN,
      rsp_payload.motor_drive == MOTOR_STOP &&
      (rsp_payload.green_light != rsp_payload.red_light),
      "countdown beat lights not exclusive")

   `TAS_ASSERT_NOW(a_extend_drive, clock, reset, rsp_valid && rsp_payload.phase == PH_EXTEND,
      rsp_payload.motor_drive == MOTOR_EXTEND && !rsp_payload.red_light,
      "extend beat with wrong drive or red light")

endmodule

bind timed_actuator_sequencer_top tas_checker u_tas_checker (.*);
